### rtl/core/lin_slave_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// LIN slave frame receiver assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LIN_SLAVE_FRAME_RECEIVER_MACROS_SVH
`define LIN_SLAVE_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define LSFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsfr check failed");

// Next-cycle implication, clocked on clk, off while rst is high.
`define LSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsfr check failed");

`endif

### rtl/core/lsfr_pkg.sv
// ----------------------------------------------------------------------------
// LIN slave frame receiver package
// Widths, reset values, register codes and shared types.
// ----------------------------------------------------------------------------
package lsfr_pkg;

  localparam int BYTE_W        = 8;
  localparam int ID_W          = 6;
  localparam int LEN_W         = 4;
  localparam int DATA_W        = 64;
  localparam int CFG_W         = 6;
  localparam int MAX_BYTES_DEF = 8;

  localparam logic [ID_W-1:0]  NODE_ID_RST   = 6'h10;
  localparam logic [LEN_W-1:0] FRAME_LEN_RST = 4'd4;

  typedef enum logic [0:0] {
    CFG_NODE_ID   = 1'b0,
    CFG_FRAME_LEN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  byte_count;
    logic              checksum_ok;
  } frame_res_t;

  // Protected identifier: P0 in bit 6, inverted P1 in bit 7.
  function automatic logic [BYTE_W-1:0] protected_id(input logic [ID_W-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

### rtl/core/lsfr_byte_if.sv
// ----------------------------------------------------------------------------
// LIN received byte channel
// Valid/ready channel carrying one bus byte per item.
// ----------------------------------------------------------------------------
interface lsfr_byte_if;
  logic                         valid;
  logic                         ready;
  logic [lsfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/lsfr_frame_if.sv
// ----------------------------------------------------------------------------
// LIN frame result channel
// Valid/ready channel carrying one received frame per item.
// ----------------------------------------------------------------------------
interface lsfr_frame_if;
  logic                         valid;
  logic                         ready;
  logic [lsfr_pkg::DATA_W-1:0]  frame_data;
  logic [lsfr_pkg::LEN_W-1:0]   byte_count;
  logic                         checksum_ok;

  modport source (output valid, output frame_data, output byte_count,
                  output checksum_ok, input ready);
  modport sink (input valid, input frame_data, input byte_count,
                input checksum_ok, output ready);
endinterface

### rtl/core/lsfr_in_stage.sv
// ----------------------------------------------------------------------------
// LIN receiver input register
// Holds one accepted byte until the frame core consumes it.
// ----------------------------------------------------------------------------
module lsfr_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  lsfr_byte_if.sink                   rx,
  input  logic                        take,
  output logic                        byte_valid,
  output logic [lsfr_pkg::BYTE_W-1:0] byte_data
);

  logic                        valid_q;
  logic [lsfr_pkg::BYTE_W-1:0] byte_q;

  assign rx.ready   = !valid_q || take;
  assign byte_valid = valid_q;
  assign byte_data  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  // Payload: load on accept, no reset.
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

endmodule

### rtl/core/lsfr_frame_core.sv
// ----------------------------------------------------------------------------
// LIN receiver frame core
// Identifier match, data collection, classic checksum and config registers.
// ----------------------------------------------------------------------------
module lsfr_frame_core #(
  parameter int MAX_BYTES = lsfr_pkg::MAX_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  lsfr_pkg::cfg_reg_t          cfg_index,
  input  logic [lsfr_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        step,
  input  logic [lsfr_pkg::BYTE_W-1:0] byte_data,
  output logic                        res_valid,
  output lsfr_pkg::frame_res_t        res
);

  localparam int BUF_W = MAX_BYTES * lsfr_pkg::BYTE_W;
  localparam logic [lsfr_pkg::LEN_W-1:0] MAX_CNT = lsfr_pkg::LEN_W'(MAX_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_CSUM = 2'd2
  } phase_t;

  phase_t                          phase;
  phase_t                          phase_next;
  logic [lsfr_pkg::ID_W-1:0]       node_id;
  logic [lsfr_pkg::LEN_W-1:0]      frame_length;
  logic [lsfr_pkg::LEN_W-1:0]      bytes_taken;
  logic [lsfr_pkg::LEN_W-1:0]      bytes_taken_next;
  logic [lsfr_pkg::BYTE_W-1:0]     running_sum;
  logic [lsfr_pkg::BYTE_W-1:0]     running_sum_next;
  logic [BUF_W-1:0]                frame_buffer;
  logic [BUF_W-1:0]                frame_buffer_next;
  logic [lsfr_pkg::LEN_W-1:0]      len_eff;
  logic [lsfr_pkg::BYTE_W:0]       sum_wide;

  always_comb begin
    if (frame_length == '0) begin
      len_eff = lsfr_pkg::LEN_W'(1);
    end else if (frame_length > MAX_CNT) begin
      len_eff = MAX_CNT;
    end else begin
      len_eff = frame_length;
    end
  end

  always_comb begin
    phase_next        = phase;
    bytes_taken_next  = bytes_taken;
    running_sum_next  = running_sum;
    frame_buffer_next = frame_buffer;
    res_valid         = 1'b0;
    sum_wide          = {1'b0, running_sum} + {1'b0, byte_data};

    res.frame_data                = '0;
    res.frame_data[BUF_W-1:0]     = frame_buffer;
    res.byte_count                = bytes_taken;
    res.checksum_ok               = (byte_data == ~running_sum);

    unique case (phase)
      PH_DATA: begin
        if (bytes_taken < MAX_CNT) begin
          for (int i = 0; i < MAX_BYTES; i++) begin
            if (bytes_taken == lsfr_pkg::LEN_W'(i)) begin
              frame_buffer_next[i*lsfr_pkg::BYTE_W +: lsfr_pkg::BYTE_W] = byte_data;
            end
          end
          bytes_taken_next = bytes_taken + lsfr_pkg::LEN_W'(1);
          // End-around carry: a sum past 0xFF wraps to sum - 0xFF.
          running_sum_next = sum_wide[lsfr_pkg::BYTE_W-1:0]
                             + lsfr_pkg::BYTE_W'(sum_wide[lsfr_pkg::BYTE_W]);
        end
        if (bytes_taken_next >= len_eff || bytes_taken_next >= MAX_CNT) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        res_valid         = step;
        phase_next        = PH_IDLE;
        bytes_taken_next  = '0;
        running_sum_next  = '0;
        frame_buffer_next = '0;
      end
      default: begin
        phase_next = PH_IDLE;
        if (byte_data == lsfr_pkg::protected_id(node_id)) begin
          phase_next        = PH_DATA;
          bytes_taken_next  = '0;
          running_sum_next  = '0;
          frame_buffer_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bytes_taken  <= '0;
      running_sum  <= '0;
      frame_buffer <= '0;
      node_id      <= lsfr_pkg::NODE_ID_RST;
      frame_length <= lsfr_pkg::FRAME_LEN_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lsfr_pkg::CFG_NODE_ID:   node_id      <= cfg_wdata[lsfr_pkg::ID_W-1:0];
          lsfr_pkg::CFG_FRAME_LEN: frame_length <= cfg_wdata[lsfr_pkg::LEN_W-1:0];
          default:                 node_id      <= node_id;
        endcase
      end
      if (step) begin
        phase        <= phase_next;
        bytes_taken  <= bytes_taken_next;
        running_sum  <= running_sum_next;
        frame_buffer <= frame_buffer_next;
      end
    end
  end

endmodule

### rtl/core/lsfr_out_stage.sv
// ----------------------------------------------------------------------------
// LIN receiver result register
// Holds one finished frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsfr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lsfr_pkg::frame_res_t res,
  output logic                 free,
  lsfr_frame_if.source         frame
);

  logic                 valid_q;
  lsfr_pkg::frame_res_t res_q;

  assign free              = !valid_q || frame.ready;
  assign frame.valid       = valid_q;
  assign frame.frame_data  = res_q.frame_data;
  assign frame.byte_count  = res_q.byte_count;
  assign frame.checksum_ok = res_q.checksum_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (frame.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

### rtl/core/lin_slave_frame_receiver.sv
// ----------------------------------------------------------------------------
// LIN slave frame receiver, classic checksum
// Matches the protected identifier, collects data bytes, checks the sum.
// ----------------------------------------------------------------------------
// Usage:
//   rx    : one received bus byte per item (valid/ready).
//   frame : one result per completed frame: data bytes packed with the first
//           byte in bits 7..0, the byte count and a checksum-ok flag.
//   cfg   : write cfg_we with cfg_index (node id or frame length) and
//           cfg_wdata; write only while no frame is in progress.
// Flow: an identifier byte that matches the configured node id opens a
//   frame; the next frame_length bytes are data (length 0 counts as 1,
//   lengths past MAX_BYTES as MAX_BYTES); the byte after that is compared
//   with the inverted end-around-carry sum and closes the frame.
// Timing: one byte per cycle while no result is stalled. A byte is held in
//   the input register and folded into the frame state at an edge with step high;
//   frame.valid rises in the cycle after the core takes its checksum byte.
// Reset: rst (synchronous) returns to identifier search, clears the frame
//   state and loads node id 0x10 and frame length 4; no result is pending.
// Stall: a result waits in the output register while frame.ready is low;
//   any byte in the input register holds there too, result or not, and
//   rx.ready drops only while a byte waits behind a stalled result.
// ----------------------------------------------------------------------------
`include "lin_slave_frame_receiver_macros.svh"

module lin_slave_frame_receiver #(
  parameter int MAX_BYTES = lsfr_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  lsfr_pkg::cfg_reg_t         cfg_index,
  input  logic [lsfr_pkg::CFG_W-1:0] cfg_wdata,
  lsfr_byte_if.sink                  rx,
  lsfr_frame_if.source               frame
);

  logic                        byte_valid;
  logic [lsfr_pkg::BYTE_W-1:0] byte_data;
  logic                        out_free;
  logic                        step;
  logic                        res_valid;
  lsfr_pkg::frame_res_t        res;

  // Advance the held byte only when the result register can take a result.
  assign step = byte_valid && out_free;

  lsfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  lsfr_frame_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  lsfr_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_valid),
    .res   (res),
    .free  (out_free),
    .frame (frame)
  );

  // A finished frame lands in the result register on the next edge.
  `LSFR_ASSERT_NEXT(a_result_lands, res_valid, frame.valid)
  // Byte count of a shown frame stays within the buffer.
  `LSFR_ASSERT_NOW(a_count_range, frame.valid,
    frame.byte_count != '0 && frame.byte_count <= lsfr_pkg::LEN_W'(MAX_BYTES))
  // Input backpressure only comes from a stalled result.
  `LSFR_ASSERT_NOW(a_stall_cause, !rx.ready, frame.valid && !frame.ready)

endmodule
